### sv/hcb_pkg.sv
// Shared constants and types for the Huffman code builder.
package hcb_pkg;
  localparam int MaxSymbols = 32;
  localparam int WeightBits = 16;
  localparam int NodeDepth  = 2 * MaxSymbols - 1;
  localparam int NodeW      = $clog2(NodeDepth);
  localparam int CountW     = $clog2(MaxSymbols + 1);
  localparam int NodeWtW    = WeightBits + $clog2(MaxSymbols);
  localparam int SymW       = 5;
  localparam int CodeW      = 31;
  localparam int LenW       = 5;

  typedef struct packed {
    logic [WeightBits-1:0] weight;
    logic                  is_last;
  } item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_MERGE,
    ST_WALK,
    ST_WALK_P,
    ST_WALK_L,
    ST_EMIT
  } bst_t;
endpackage

### sv/hcb_front.sv
// Input side: accepts weight transfers and queues them for the build engine.
module hcb_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  hcb_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_pop,
  output hcb_pkg::item_t q_item
);
  hcb_pkg::item_t buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = buf_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= in_item;
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> in_stall) else $error("full queue not stalling");
endmodule

### sv/hcb_back.sv
// Build engine: stores weights, merges nodes, walks the tree and emits codes.
module hcb_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  hcb_pkg::item_t              q_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hcb_pkg::SymW-1:0]    out_symbol_index,
  output logic [hcb_pkg::CodeW-1:0]   out_code_bits,
  output logic [hcb_pkg::LenW-1:0]    out_code_length,
  output logic                        out_final_code
);
  logic [hcb_pkg::NodeWtW-1:0] wt_mem  [hcb_pkg::NodeDepth];
  logic [hcb_pkg::NodeW-1:0]   par_mem [hcb_pkg::NodeDepth];
  logic [hcb_pkg::NodeW-1:0]   lc_mem  [hcb_pkg::NodeDepth];
  logic [hcb_pkg::NodeDepth-1:0] hasp_r;

  hcb_pkg::bst_t st_r, st_nxt;
  logic [hcb_pkg::CountW-1:0]  cnt_r;
  logic [hcb_pkg::NodeW-1:0]   n_r, nn_r, idx_r, a_r, b_r, best_r, sym_r, cur_r;
  logic [hcb_pkg::NodeW-1:0]   pidx_r, par_rd_r, lc_rd_r;
  logic                        found_r, pv_r;
  logic [hcb_pkg::NodeWtW-1:0] bestw_r, wa_r, wb_r, rdw_r;
  logic [hcb_pkg::CodeW-1:0]   code_r;
  logic [hcb_pkg::LenW-1:0]    len_r;
  logic                        ov_r;

  logic        scan_end, cand, walk_end, out_take;

  assign out_take = out_valid && !out_stall;
  // a scan ends once every node is issued and the last read has been compared
  assign scan_end = (idx_r == nn_r) && !pv_r;
  assign cand = !hasp_r[pidx_r] && !(st_r == hcb_pkg::ST_SCAN_B && pidx_r == a_r) &&
                (!found_r || rdw_r < bestw_r);
  assign walk_end = !hasp_r[cur_r] || (len_r == hcb_pkg::LenW'(hcb_pkg::CodeW));
  assign q_pop = (st_r == hcb_pkg::ST_LOAD) && q_valid && !ov_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      hcb_pkg::ST_LOAD:
        if (q_pop && q_item.is_last) begin
          st_nxt = (cnt_r == '0) ? hcb_pkg::ST_WALK : hcb_pkg::ST_SCAN_A;
        end
      hcb_pkg::ST_SCAN_A: if (scan_end) st_nxt = hcb_pkg::ST_SCAN_B;
      hcb_pkg::ST_SCAN_B: if (scan_end) st_nxt = hcb_pkg::ST_MERGE;
      hcb_pkg::ST_MERGE:
        st_nxt = (nn_r + 1'b1 == n_r + n_r - 1'b1) ? hcb_pkg::ST_WALK : hcb_pkg::ST_SCAN_A;
      hcb_pkg::ST_WALK: st_nxt = walk_end ? hcb_pkg::ST_EMIT : hcb_pkg::ST_WALK_P;
      hcb_pkg::ST_WALK_P: st_nxt = hcb_pkg::ST_WALK_L;
      hcb_pkg::ST_WALK_L: st_nxt = hcb_pkg::ST_WALK;
      hcb_pkg::ST_EMIT:
        if (out_take) st_nxt = (sym_r + 1'b1 == n_r) ? hcb_pkg::ST_LOAD : hcb_pkg::ST_WALK;
      default: st_nxt = hcb_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    out_valid        = (st_r == hcb_pkg::ST_EMIT);
    out_symbol_index = hcb_pkg::SymW'(sym_r);
    out_code_bits    = code_r;
    out_code_length  = len_r;
    out_final_code   = (sym_r + 1'b1 == n_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= hcb_pkg::ST_LOAD;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= 1'b0;
      if (q_pop) begin
        if (q_item.is_last) cnt_r <= '0;
        else if (cnt_r != hcb_pkg::CountW'(hcb_pkg::MaxSymbols)) cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // datapath; a last item counts as a symbol even with nothing stored, but not with no slot left
  logic [hcb_pkg::NodeW:0] nfin;
  always_comb begin
    nfin = (cnt_r == hcb_pkg::CountW'(hcb_pkg::MaxSymbols)) ? (hcb_pkg::NodeW+1)'(cnt_r)
         : (hcb_pkg::NodeW+1)'(cnt_r) + 1'b1;
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      hcb_pkg::ST_LOAD: begin
        if (q_pop) begin
          if (cnt_r != hcb_pkg::CountW'(hcb_pkg::MaxSymbols))
            wt_mem[cnt_r[hcb_pkg::NodeW-1:0]] <= hcb_pkg::NodeWtW'(q_item.weight);
          if (q_item.is_last) begin
            n_r    <= hcb_pkg::NodeW'(nfin);
            nn_r   <= hcb_pkg::NodeW'(nfin);
            hasp_r <= '0;
            idx_r  <= '0;
            pv_r   <= 1'b0;
            found_r <= 1'b0;
            sym_r  <= '0;
            cur_r  <= '0;
            code_r <= '0;
            len_r  <= '0;
          end
        end
      end
      hcb_pkg::ST_SCAN_A, hcb_pkg::ST_SCAN_B: begin
        if (scan_end) begin
          if (st_r == hcb_pkg::ST_SCAN_A) begin
            a_r <= best_r; wa_r <= bestw_r;
          end else begin
            b_r <= best_r; wb_r <= bestw_r;
          end
          par_mem[best_r] <= nn_r;
          idx_r <= '0;
          found_r <= 1'b0;
        end else begin
          // compare the node read last cycle while the next read is issued
          if (pv_r && cand) begin
            best_r <= pidx_r; bestw_r <= rdw_r; found_r <= 1'b1;
          end
          if (idx_r != nn_r) begin
            rdw_r  <= wt_mem[idx_r];
            pidx_r <= idx_r;
            idx_r  <= idx_r + 1'b1;
          end
          pv_r <= (idx_r != nn_r);
        end
      end
      hcb_pkg::ST_MERGE: begin
        hasp_r[a_r] <= 1'b1;
        hasp_r[b_r] <= 1'b1;
        lc_mem[nn_r] <= a_r;
        wt_mem[nn_r] <= wa_r + wb_r;
        nn_r <= nn_r + 1'b1;
      end
      hcb_pkg::ST_WALK: begin
        if (!walk_end) par_rd_r <= par_mem[cur_r];
      end
      hcb_pkg::ST_WALK_P: begin
        lc_rd_r <= lc_mem[par_rd_r];
      end
      hcb_pkg::ST_WALK_L: begin
        if (lc_rd_r != cur_r) code_r[len_r] <= 1'b1;
        len_r <= len_r + 1'b1;
        cur_r <= par_rd_r;
      end
      hcb_pkg::ST_EMIT: begin
        if (out_take) begin
          sym_r  <= sym_r + 1'b1;
          cur_r  <= sym_r + 1'b1;
          code_r <= '0;
          len_r  <= '0;
        end
      end
      default: ;
    endcase
  end

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_bits))
    else $error("stalled result changed");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != hcb_pkg::ST_LOAD) |-> !q_pop) else $error("pop during build");
  a_merge_next: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == hcb_pkg::ST_MERGE) |=> (st_r == hcb_pkg::ST_SCAN_A || st_r == hcb_pkg::ST_WALK))
    else $error("bad merge successor");
endmodule

### sv/huffman_code_builder.sv
// Top level of the Huffman code builder: input queue plus build engine.
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_stall   | in_weight, in_is_last
// out     | output    | out_valid/out_stall | symbol_index, code_bits, code_length, final_code
// Each weight is one transfer. For a set of n weights, the merge that makes node k
// (k = n..2n-2) scans k nodes twice, once for each of the two lightest parentless nodes.
// Each code walks its leaf-to-root path one level per pass through WALK, WALK_P and
// WALK_L, sees the root in WALK, then waits in EMIT until taken. Synchronous active-low
// reset returns to loading. The queue drains only while loading, so input stalls once it
// fills during a build; results hold under out_stall.
module huffman_code_builder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hcb_pkg::WeightBits-1:0]  in_weight,
  input  logic                            in_is_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hcb_pkg::SymW-1:0]        out_symbol_index,
  output logic [hcb_pkg::CodeW-1:0]       out_code_bits,
  output logic [hcb_pkg::LenW-1:0]        out_code_length,
  output logic                            out_final_code
);
  hcb_pkg::item_t in_item, q_item;
  logic q_valid, q_pop;

  assign in_item.weight  = in_weight;
  assign in_item.is_last = in_is_last;

  hcb_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_item, .q_valid, .q_pop, .q_item
  );

  hcb_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_item, .out_valid, .out_stall,
    .out_symbol_index, .out_code_bits, .out_code_length, .out_final_code
  );
endmodule

### bench/huffman_code_builder_tb.sv
// Testbench for the Huffman code builder: random weight sets, scoreboard against a tree model.
`timescale 1ns / 100ps

module huffman_code_builder_tb;

  typedef struct {
    logic [hcb_pkg::SymW-1:0]  sym;
    logic [hcb_pkg::CodeW-1:0] bits;
    logic [hcb_pkg::LenW-1:0]  len;
    logic                      fin;
  } code_t;

  class code_scoreboard;
    logic [hcb_pkg::NodeWtW-1:0] wt [hcb_pkg::NodeDepth];
    int                 parent [hcb_pkg::NodeDepth];
    bit                 has_par [hcb_pkg::NodeDepth];
    int                 left [hcb_pkg::NodeDepth];
    int                 count;
    code_t              pending [$];
    int                 mismatches;

    function new();
      count = 0;
      mismatches = 0;
    endfunction

    function int lightest(int lim, int skip);
      int  best;
      bit  found;
      best = 0;
      found = 0;
      for (int i = 0; i < lim; i++) begin
        if (has_par[i] || i == skip) continue;
        if (!found || wt[i] < wt[best]) begin
          best = i;
          found = 1;
        end
      end
      return best;
    endfunction

    function void note_weight(logic [hcb_pkg::WeightBits-1:0] w, logic last);
      int    n, a, b, c, l;
      code_t r;
      if (count < hcb_pkg::MaxSymbols) begin
        wt[count] = hcb_pkg::NodeWtW'(w);
        count++;
      end
      if (!last) return;
      n = count;
      count = 0;
      for (int i = 0; i < hcb_pkg::NodeDepth; i++) has_par[i] = 0;
      for (int i = n; i < 2 * n - 1; i++) begin
        a = lightest(i, hcb_pkg::NodeDepth);
        b = lightest(i, a);
        parent[a] = i;
        parent[b] = i;
        has_par[a] = 1;
        has_par[b] = 1;
        left[i] = a;
        wt[i] = wt[a] + wt[b];
      end
      for (int s = 0; s < n; s++) begin
        r.bits = '0;
        l = 0;
        c = s;
        while (has_par[c] && l < 31) begin
          if (left[parent[c]] != c) r.bits[l] = 1'b1;
          l++;
          c = parent[c];
        end
        r.sym = hcb_pkg::SymW'(s);
        r.len = hcb_pkg::LenW'(l);
        r.fin = (s == n - 1);
        pending.push_back(r);
      end
    endfunction

    function void check_code(code_t got);
      code_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected code for symbol %0d", got.sym);
        return;
      end
      want = pending.pop_front();
      if (got.sym !== want.sym || got.bits !== want.bits || got.len !== want.len ||
          got.fin !== want.fin) begin
        mismatches++;
        if (mismatches <= 10)
          $display("code mismatch: exp sym %0d bits %h len %0d fin %0d, got %0d %h %0d %0d",
                   want.sym, want.bits, want.len, want.fin,
                   got.sym, got.bits, got.len, got.fin);
      end
    endfunction
  endclass

  logic                           clk, rst_n;
  logic                           in_valid, in_stall, in_is_last;
  logic [hcb_pkg::WeightBits-1:0] in_weight;
  logic                           out_valid, out_stall, out_final_code;
  logic [hcb_pkg::SymW-1:0]       out_symbol_index;
  logic [hcb_pkg::CodeW-1:0]      out_code_bits;
  logic [hcb_pkg::LenW-1:0]       out_code_length;

  code_scoreboard sb;
  bit             calm;
  int             quiet;

  huffman_code_builder dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function bit idle_now();
    return !calm && $urandom_range(99) < 32;
  endfunction

  // Hold each weight until its transfer; idle only between items.
  task automatic send_weight(logic [hcb_pkg::WeightBits-1:0] w, logic last);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_weight  <= w;
    in_is_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_weight(w, last);
  endtask

  function logic [hcb_pkg::WeightBits-1:0] rand_weight();
    unique case ($urandom_range(5))
      0: return '1;
      1: return hcb_pkg::WeightBits'($urandom_range(3));
      2: return hcb_pkg::WeightBits'($urandom_range(16));
      default: return hcb_pkg::WeightBits'($urandom);
    endcase
  endfunction

  task automatic send_set(int n);
    for (int i = 0; i < n; i++) send_weight(rand_weight(), i == n - 1);
  endtask

  always @(posedge clk) begin
    code_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.sym  = out_symbol_index;
        got.bits = out_code_bits;
        got.len  = out_code_length;
        got.fin  = out_final_code;
        sb.check_code(got);
      end
      out_stall <= idle_now();
      quiet <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ? 0 : quiet + 1;
      if (quiet > 20000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    sb = new();
    calm = 0;
    quiet = 0;
    rst_n = 0;
    in_valid = 0;
    in_weight = '0;
    in_is_last = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: single symbol, zero and max weights, ties, skewed set, full set, overflow.
    send_weight(16'd7, 1'b1);
    send_weight(16'd0, 1'b0);
    send_weight(16'hFFFF, 1'b1);
    send_weight(16'd5, 1'b0);
    send_weight(16'd5, 1'b0);
    send_weight(16'd5, 1'b1);
    for (int i = 0; i < 6; i++) send_weight(16'd1 << (2 * i), i == 5);
    for (int i = 0; i < 34; i++) send_weight(hcb_pkg::WeightBits'($urandom), i == 33);
    sent = 46;
    // Random sets, mostly small, with a calm stretch.
    while (sent < 130) begin
      int n;
      calm = (sent > 60 && sent < 100);
      n = ($urandom_range(9) == 0) ? $urandom_range(32, 34) : $urandom_range(1, 8);
      send_set(n);
      sent += n;
    end
    calm = 0;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
